FILE: rtl/core/wft_pkg.sv
// Shared types and constants for the warning flag table.
package wft_pkg;

    localparam int NUM_WHEELS     = 4;
    localparam int NUM_TYPES      = 8;
    localparam int NUM_ATTR_SLOTS = 4;

    localparam int FLAG_W     = 8;
    localparam int WF_DEPTH   = NUM_WHEELS * NUM_ATTR_SLOTS;
    localparam int WF_IDX_W   = (WF_DEPTH > 1) ? $clog2(WF_DEPTH) : 1;
    localparam int WHEEL_IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic CFG_IDX_FILTER_MASK = 1'b0;

    localparam logic [FLAG_W-1:0] TYPE_BIT [8] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
    };

    typedef enum logic [1:0] {
        REQ_SET      = 2'd0,
        REQ_CLR_TYPE = 2'd1,
        REQ_CLR_ATTR = 2'd2,
        REQ_GET      = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [2:0] attr_index;
        logic [2:0] warn_type;
        logic [2:0] wheel_index;
        req_kind_t  req_type;
    } wft_req_t;

    typedef struct packed {
        logic bad_request;
        logic flag_value;
    } wft_rsp_t;

endpackage

FILE: rtl/core/wft_cfg.sv
// APB register block holding the first-hit filter enable mask.
module wft_cfg
    import wft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [FLAG_W-1:0]     filter_enable_mask
);

    logic [FLAG_W-1:0] mask_reg;
    logic [FLAG_W-1:0] mask_next;
    logic              reg_sel;

    assign pready  = 1'b1;
    // Register index sits above the byte offset.
    assign reg_sel = (paddr[2] == CFG_IDX_FILTER_MASK);

    always_comb
    begin
        mask_next = mask_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            mask_next = pwdata[FLAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    assign prdata = reg_sel ? {{(CFG_DATA_W-FLAG_W){1'b0}}, mask_reg} : '0;
    assign filter_enable_mask = mask_reg;

endmodule

FILE: rtl/core/wft_table.sv
// Flag and first-hit storage with the single-pass read-modify-write logic.
module wft_table
    import wft_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  wft_req_t          req,
    input  logic [FLAG_W-1:0] filter_enable_mask,
    output wft_rsp_t          rsp
);

    logic [FLAG_W-1:0] wf_reg   [WF_DEPTH];
    logic [FLAG_W-1:0] wf_next  [WF_DEPTH];
    logic [FLAG_W-1:0] fh_reg   [NUM_WHEELS];
    logic [FLAG_W-1:0] fh_next  [NUM_WHEELS];

    logic                   ok_wt;
    logic                   ok_all;
    logic [FLAG_W-1:0]      bit_mask;
    logic [6:0]             flat_wide;
    logic [WF_IDX_W-1:0]    flat_idx;
    logic [WHEEL_IDX_W-1:0] wheel_idx;
    logic [FLAG_W-1:0]      cur_word;
    logic [FLAG_W-1:0]      cur_fh;
    logic                   cur_hit;

    assign ok_wt  = ({1'b0, req.wheel_index} < 4'(NUM_WHEELS))
                 && ({1'b0, req.warn_type} < 4'(NUM_TYPES));
    assign ok_all = ok_wt && ({1'b0, req.attr_index} < 4'(NUM_ATTR_SLOTS));

    assign bit_mask  = TYPE_BIT[req.warn_type];
    assign flat_wide = 7'(req.wheel_index) * 7'(NUM_ATTR_SLOTS) + 7'(req.attr_index);
    assign flat_idx  = flat_wide[WF_IDX_W-1:0];
    assign wheel_idx = req.wheel_index[WHEEL_IDX_W-1:0];
    assign cur_word  = wf_reg[flat_idx];
    assign cur_fh    = fh_reg[wheel_idx];
    assign cur_hit   = |(cur_word & bit_mask);

    always_comb
    begin
        logic [6:0] slot_wide;
        wf_next = wf_reg;
        fh_next = fh_reg;
        rsp     = '0;
        slot_wide = '0;
        case (req.req_type)
            REQ_CLR_TYPE:
            begin
                if (!ok_wt)
                begin
                    rsp.bad_request = 1'b1;
                end
                else if (fire)
                begin
                    fh_next[wheel_idx] = cur_fh & ~bit_mask;
                    for (int s = 0; s < NUM_ATTR_SLOTS; s++)
                    begin
                        slot_wide = 7'(req.wheel_index) * 7'(NUM_ATTR_SLOTS) + 7'(s);
                        wf_next[slot_wide[WF_IDX_W-1:0]] =
                            wf_reg[slot_wide[WF_IDX_W-1:0]] & ~bit_mask;
                    end
                end
            end
            REQ_SET:
            begin
                if (!ok_all)
                begin
                    rsp.bad_request = 1'b1;
                end
                else if (cur_hit)
                begin
                    rsp.flag_value = 1'b1;
                end
                else if (!(|(cur_fh & bit_mask)) && (|(filter_enable_mask & bit_mask)))
                begin
                    // First hit only: note it and hold the flag clear.
                    if (fire)
                    begin
                        fh_next[wheel_idx] = cur_fh | bit_mask;
                    end
                end
                else
                begin
                    rsp.flag_value = 1'b1;
                    if (fire)
                    begin
                        wf_next[flat_idx] = cur_word | bit_mask;
                    end
                end
            end
            REQ_CLR_ATTR:
            begin
                if (!ok_all)
                begin
                    rsp.bad_request = 1'b1;
                end
                else if (fire)
                begin
                    wf_next[flat_idx] = cur_word & ~bit_mask;
                end
            end
            REQ_GET:
            begin
                if (!ok_all)
                begin
                    rsp.bad_request = 1'b1;
                end
                else
                begin
                    rsp.flag_value = cur_hit;
                end
            end
            default:
            begin
                rsp = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WF_DEPTH; i++)
            begin
                wf_reg[i] <= '0;
            end
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                fh_reg[w] <= '0;
            end
        end
        else
        begin
            wf_reg <= wf_next;
            fh_reg <= fh_next;
        end
    end

endmodule

FILE: rtl/core/warning_flag_table_with_first_hit_filter.sv
// Top level of the warning flag table with first-hit filter.
//
// Each request passes through the input register and then the result
// register: one result per request, and a new request every cycle as long
// as results are taken. A single read-modify-write of the table lies
// between those two registers (clear type covers a whole wheel); the table is
// updated at the same edge that loads the result, so a request right behind
// sees the new state. Requests: 0 set, 1 clear type for a wheel, 2 clear one
// attribute flag, 3 get. An out-of-range wheel, type or slot (clear type
// checks wheel and type only) answers bad_request with flag_value 0 and
// changes nothing. A set on a clear flag whose type has its filter bit on in
// filter_enable_mask (APB byte address 0) and whose first-hit bit is clear
// only records the first hit and answers 0. Write the mask while idle.
module warning_flag_table_with_first_hit_filter
    import wft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [1:0] req_type, [4:2] wheel_index, [7:5] warn_type, [10:8] attr_index
    input  logic [15:0]           s_tdata,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] flag_value, [1] bad_request
    output logic [7:0]            m_tdata,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic              in_valid_reg;
    logic              in_valid_next;
    wft_req_t          in_req_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    wft_rsp_t          out_rsp_reg;
    wft_rsp_t          rsp;
    logic              advance;
    logic              fire;
    logic              take_in;
    logic [FLAG_W-1:0] filter_enable_mask;

    wft_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .filter_enable_mask (filter_enable_mask)
    );

    // Advance the input stage whenever the result register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    wft_table u_table (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (fire),
        .req                (in_req_reg),
        .filter_enable_mask (filter_enable_mask),
        .rsp                (rsp)
    );

    assign in_valid_next  = take_in || (in_valid_reg && !advance);
    assign out_valid_next = fire || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture a new request on transfer, hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_req_reg <= wft_req_t'(s_tdata[10:0]);
        end
        if (fire)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_rsp_reg};

    // A rejected request never reports a flag.
    a_bad_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_rsp_reg.bad_request && out_rsp_reg.flag_value))
        else $error("bad_request with flag_value set");

    // A request only waits in the input stage when the result side is full.
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without downstream backpressure");

    // A request with a free result register reaches it in the next cycle.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("request did not advance to result register");

endmodule
